// ----- hdl/dd_odo_pkg.sv -----
package dd_odo_pkg;

   // payload widths of the stream and register ports
   localparam int INC_W      = 24;
   localparam int POSE_W     = 32;
   localparam int GEO_W      = 24;
   localparam int CSR_IDX_W  = 8;
   localparam int REQ_DATA_W = 2 * INC_W + 3 * POSE_W;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 3 * POSE_W;
   localparam int RSP_USER_W = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MOTOR_RADIUS    = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MOTOR_SPACING   = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ENCODER_RADIUS  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ENCODER_SPACING = 8'd3;
   localparam logic [GEO_W-1:0]     GEO_RESET           = 24'd65536;

   // round(2^32/pi) and cordic gain 0.60725 in q1.30
   localparam logic signed [32:0] INV_PI_Q32      = 33'sd1367130551;
   localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;

   typedef logic signed [32:0] vec_type;

   // atan(2^-i) as binary angle
   function automatic logic [31:0] atan_angle(input logic [4:0] idx);
      logic [31:0] r;
      unique case (idx)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;
         5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;
         5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;
         5'd29: r = 32'h00000001;
         5'd30: r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

   // clamp a 37-bit sum to 32-bit signed, msb of result is the clip flag
   function automatic logic [32:0] sat32(input logic signed [36:0] v);
      logic [32:0] r;
      if (v > 37'sd2147483647) begin
         r = {1'b1, 32'h7FFFFFFF};
      end else if (v < -37'sd2147483648) begin
         r = {1'b1, 32'h80000000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

endpackage

// ----- hdl/differential_drive_odometry.sv -----
// differential drive odometry, dead reckoning on a 32-bit pose
//
// req channel: one transfer is one step. req_tuser[0] selects the kind:
// 0 integrates the left/right wheel increments with the motor or encoder
// geometry (req_tuser[1]), 1 loads x, y and heading from the pose fields.
// rsp channel: one transfer per step with the updated pose and two flags.
// csr channel: writes the four geometry registers, always ready; only
// write it while no step is in flight.
//
// a set-pose step loads the pose and goes straight to the output stage;
// an integrate step passes the sequencer states in order: linear and
// angular products, the bit-serial divider for angular = d*R/S, angle
// scaling, the cordic rotator, then the x and y updates. Most of these
// states pass through the one shared 33x33 multiplier. With zero spacing
// the divider and the angle scaling are skipped. req_tready is high only
// while the sequencer is idle, so one step is in flight at a time and the
// next request is taken in the cycle its response appears.
// reset clears the pose to zero and the geometry registers to 1.0. A
// stalled response sits in its output register; the next request is
// still taken and worked on, and its result waits until the register frees.
module differential_drive_odometry #(
   parameter int CORDIC_STEPS = 24,
   parameter int ANGLE_BITS   = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // left_increment, right_increment, new_x, new_y, new_heading
   input  logic [dd_odo_pkg::REQ_DATA_W-1:0]    req_tdata,
   // req_type, use_encoder_geometry
   input  logic [dd_odo_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // pos_x, pos_y, heading
   output logic [dd_odo_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // saturated, zero_spacing
   output logic [dd_odo_pkg::RSP_USER_W-1:0]    rsp_tuser,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dd_odo_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dd_odo_pkg::GEO_W-1:0]         csr_data
);
   import dd_odo_pkg::*;

   // sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_LIN   = 4'd1;
   localparam logic [3:0] ST_ANG   = 4'd2;
   localparam logic [3:0] ST_DIV   = 4'd3;
   localparam logic [3:0] ST_Q0    = 4'd4;
   localparam logic [3:0] ST_Q1    = 4'd5;
   localparam logic [3:0] ST_CINIT = 4'd6;
   localparam logic [3:0] ST_CORD  = 4'd7;
   localparam logic [3:0] ST_MX    = 4'd8;
   localparam logic [3:0] ST_MY    = 4'd9;
   localparam logic [3:0] ST_DONE  = 4'd10;

   localparam int          QUO_W     = 60;
   localparam logic [5:0]  DIV_LAST  = 6'(QUO_W - 1);
   localparam logic [4:0]  STEP_LAST = 5'(CORDIC_STEPS - 1);
   localparam logic [31:0] ANGLE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

   // geometry registers
   logic [GEO_W-1:0] mot_rad_ff, mot_spc_ff, enc_rad_ff, enc_spc_ff;

   // sequencer and datapath registers
   logic [3:0]              state_ff, state_in;
   logic [5:0]              cnt_ff, cnt_in;
   logic signed [24:0]      sum_ff, sum_in, dif_ff, dif_in;
   logic                    enc_ff, enc_in;
   logic signed [28:0]      lin_ff, lin_in;
   logic                    neg_ff, neg_in;
   logic [QUO_W-1:0]        quo_ff, quo_in;
   logic [GEO_W-1:0]        rem_ff, rem_in;
   logic [63:0]             acc_ff, acc_in;
   logic [31:0]             x_ff, x_in, y_ff, y_in, hd_ff, hd_in;
   vec_type                 cx_ff, cx_in, cy_ff, cy_in;
   logic signed [33:0]      z_ff, z_in;
   logic                    flip_ff, flip_in;
   logic                    clip_ff, clip_in, zsp_ff, zsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0]   rsp_user_ff, rsp_user_in;

   // shared datapath
   logic [GEO_W-1:0]        radius, spacing;
   vec_type                 mul_a, mul_b, cos_val, sin_val;
   logic signed [65:0]      product, prod_abs, rnd_lin, rnd_pos;
   logic [24:0]             trial;
   logic [25:0]             diff;
   logic [65:0]             total;
   logic [31:0]             u_step, angle_a;
   logic [4:0]              idx;
   vec_type                 xs, ys;
   logic [31:0]             at;
   logic signed [36:0]      pos_sum;
   logic [32:0]             pos_sat;
   logic signed [23:0]      left_inc, right_inc;
   logic signed [32:0]      lin_ext;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign left_inc  = req_tdata[INC_W-1:0];
   assign right_inc = req_tdata[2*INC_W-1:INC_W];

   assign radius  = enc_ff ? enc_rad_ff : mot_rad_ff;
   assign spacing = enc_ff ? enc_spc_ff : mot_spc_ff;
   assign lin_ext = {{4{lin_ff[28]}}, lin_ff};
   assign cos_val = flip_ff ? -cx_ff : cx_ff;
   assign sin_val = flip_ff ? -cy_ff : cy_ff;

   // one multiplier, operands picked by the sequencer
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_LIN: begin
            mul_a = {{8{sum_ff[24]}}, sum_ff};
            mul_b = {9'd0, radius};
         end
         ST_ANG: begin
            mul_a = {{8{dif_ff[24]}}, dif_ff};
            mul_b = {9'd0, radius};
         end
         ST_Q0: begin
            mul_a = {1'b0, quo_ff[31:0]};
            mul_b = INV_PI_Q32;
         end
         ST_Q1: begin
            mul_a = {5'd0, quo_ff[QUO_W-1:32]};
            mul_b = INV_PI_Q32;
         end
         ST_MX: begin
            mul_a = cos_val;
            mul_b = lin_ext;
         end
         ST_MY: begin
            mul_a = sin_val;
            mul_b = lin_ext;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign product  = mul_a * mul_b;
   assign prod_abs = product[65] ? -product : product;
   assign rnd_lin  = product + 66'sd1048576;
   assign rnd_pos  = product + 66'sd536870912;

   // restoring divider step
   assign trial = {rem_ff, quo_ff[QUO_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, spacing};

   // upper half of q*C added onto the registered lower half
   assign total  = {2'b00, acc_ff} + {product[33:0], 32'd0};
   assign u_step = total[65:34];

   // cordic micro-rotation
   assign idx     = cnt_ff[4:0];
   assign xs      = cx_ff >>> idx;
   assign ys      = cy_ff >>> idx;
   assign at      = atan_angle(idx);
   assign angle_a = hd_ff & ANGLE_MASK;

   // position update with saturation, the offset sign-extended to 37 bits
   assign pos_sum = (state_ff == ST_MX)
                  ? ({{5{x_ff[31]}}, x_ff} + {rnd_pos[65], rnd_pos[65:30]})
                  : ({{5{y_ff[31]}}, y_ff} + {rnd_pos[65], rnd_pos[65:30]});
   assign pos_sat = sat32(pos_sum);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      dif_in       = dif_ff;
      enc_in       = enc_ff;
      lin_in       = lin_ff;
      neg_in       = neg_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      acc_in       = acc_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      hd_in        = hd_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      z_in         = z_ff;
      flip_in      = flip_ff;
      clip_in      = clip_ff;
      zsp_in       = zsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser[0]) begin
                  x_in     = req_tdata[2*INC_W+POSE_W-1:2*INC_W];
                  y_in     = req_tdata[2*INC_W+2*POSE_W-1:2*INC_W+POSE_W];
                  hd_in    = req_tdata[2*INC_W+3*POSE_W-1:2*INC_W+2*POSE_W];
                  clip_in  = 1'b0;
                  zsp_in   = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  sum_in   = 25'(right_inc) + 25'(left_inc);
                  dif_in   = 25'(right_inc) - 25'(left_inc);
                  enc_in   = req_tuser[1];
                  clip_in  = 1'b0;
                  state_in = ST_LIN;
               end
            end
         end
         ST_LIN: begin
            lin_in   = rnd_lin[49:21];
            state_in = ST_ANG;
         end
         ST_ANG: begin
            quo_in = {prod_abs[47:0], 12'd0};
            rem_in = '0;
            neg_in = product[65];
            cnt_in = '0;
            if (spacing == '0) begin
               zsp_in   = 1'b1;
               state_in = ST_CINIT;
            end else begin
               zsp_in   = 1'b0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            quo_in = {quo_ff[QUO_W-2:0], !diff[25]};
            rem_in = diff[25] ? trial[23:0] : diff[23:0];
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_Q0;
            end
         end
         ST_Q0: begin
            acc_in   = product[63:0] + 64'h2_0000_0000;
            state_in = ST_Q1;
         end
         ST_Q1: begin
            hd_in    = neg_ff ? (hd_ff - u_step) : (hd_ff + u_step);
            state_in = ST_CINIT;
         end
         ST_CINIT: begin
            // second and third quarter turns: rotate by a half turn, negate after
            flip_in  = angle_a[31] ^ angle_a[30];
            z_in     = {{2{angle_a[31] ^ angle_a[30] ^ angle_a[31]}},
                        angle_a[31] ^ angle_a[30] ^ angle_a[31], angle_a[30:0]};
            cx_in    = CORDIC_GAIN_Q30;
            cy_in    = '0;
            cnt_in   = '0;
            state_in = ST_CORD;
         end
         ST_CORD: begin
            if (!z_ff[33]) begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               z_in  = z_ff - 34'(at);
            end else begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               z_in  = z_ff + 34'(at);
            end
            cnt_in = cnt_ff + 6'd1;
            if (idx == STEP_LAST) begin
               state_in = ST_MX;
            end
         end
         ST_MX: begin
            x_in     = pos_sat[31:0];
            clip_in  = pos_sat[32];
            state_in = ST_MY;
         end
         ST_MY: begin
            y_in     = pos_sat[31:0];
            clip_in  = clip_ff | pos_sat[32];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {hd_ff, y_ff, x_ff};
               rsp_user_in  = {zsp_ff, clip_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         x_ff         <= '0;
         y_ff         <= '0;
         hd_ff        <= '0;
         mot_rad_ff   <= GEO_RESET;
         mot_spc_ff   <= GEO_RESET;
         enc_rad_ff   <= GEO_RESET;
         enc_spc_ff   <= GEO_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         hd_ff        <= hd_in;
         if (csr_valid) begin
            unique case (csr_index)
               REG_MOTOR_RADIUS:    mot_rad_ff <= csr_data;
               REG_MOTOR_SPACING:   mot_spc_ff <= csr_data;
               REG_ENCODER_RADIUS:  enc_rad_ff <= csr_data;
               REG_ENCODER_SPACING: enc_spc_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      sum_ff      <= sum_in;
      dif_ff      <= dif_in;
      enc_ff      <= enc_in;
      lin_ff      <= lin_in;
      neg_ff      <= neg_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      acc_ff      <= acc_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      z_ff        <= z_in;
      flip_ff     <= flip_in;
      clip_ff     <= clip_in;
      zsp_ff      <= zsp_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule

// ----- hdl/dd_odo_checker.sv -----
module dd_odo_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [dd_odo_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input logic [dd_odo_pkg::RSP_USER_W-1:0]    rsp_tuser
);

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // one step in flight: no request taken right after a transfer in
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // no response straight out of reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind differential_drive_odometry dd_odo_checker u_dd_odo_checker (.*);
